// File: src/sv32ptw_pkg.sv
`timescale 1ns / 1ps

package sv32ptw_pkg;

  localparam int VADDR_W     = 32;
  localparam int PADDR_W     = 32;
  localparam int PTE_W       = 32;
  localparam int VPN_W       = 10;
  localparam int OFFSET_W    = 12;
  localparam int PPN_W       = 22;
  localparam int ACCESS_W    = 2;
  localparam int KIND_W      = 2;
  localparam int FAULT_W     = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = PPN_W;

  // stream payload widths, rounded up to whole bytes
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 72;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATION_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_PPN           = 1'b1;

  // input selector carried in s_tuser
  localparam logic MODE_REQUEST  = 1'b0;
  localparam logic MODE_RESPONSE = 1'b1;

  // result kinds carried in m_tuser
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_NONE       = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_L1_INVALID = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_SUPERPAGE  = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_L0_INVALID = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_PERMISSION = 3'd4;

  localparam logic [ACCESS_W-1:0] ACCESS_FETCH = 2'd0;
  localparam logic [ACCESS_W-1:0] ACCESS_LOAD  = 2'd1;

  // PTE flag bit positions
  localparam int PTE_V_BIT = 0;
  localparam int PTE_R_BIT = 1;
  localparam int PTE_W_BIT = 2;
  localparam int PTE_X_BIT = 3;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_L1   = 2'd1,
    PHASE_L0   = 2'd2
  } phase_t;

  typedef struct packed {
    logic                mode;
    logic [VADDR_W-1:0]  vaddr;
    logic [ACCESS_W-1:0] access_kind;
    logic [PTE_W-1:0]    read_data;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [PADDR_W-1:0] mem_addr;
    logic [PADDR_W-1:0] paddr;
    logic [FAULT_W-1:0] fault_code;
  } res_item_t;

endpackage

// File: src/sv32_page_table_walker.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake          Payload
// s_*       in    s_tvalid/s_tready  tuser: mode; tdata: vaddr, access_kind, read_data
// m_*       out   m_tvalid/m_tready  tuser: result_kind; tdata: mem_addr, paddr, fault_code
// cfg_*     in    cfg_we             cfg_index, cfg_data
//
// One item per cycle sustained while m_tready holds. An item waits in the input register,
// then its result (if any) lands in the output register.
// rst is synchronous; it empties both registers and returns the walk to idle.
// s_tready follows m_tready combinationally, so a stall on the result side
// holds the input side after one buffered item.

module sv32_page_table_walker
  import sv32ptw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // vaddr[31:0], access_kind[33:32], read_data[65:34]
  input  logic                   s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // mem_addr[31:0], paddr[63:32], fault_code[66:64]
  output logic [KIND_W-1:0]      m_tuser,   // result_kind
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic             translation_enable;
  logic [PPN_W-1:0] root_ppn;

  logic      in_valid;
  in_item_t  in_item;
  logic      out_ready;
  logic      fire;
  logic      res_valid;
  res_item_t res;
  res_item_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      translation_enable <= 1'b0;
      root_ppn           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANSLATION_ENABLE: translation_enable <= cfg_data[0];
        CFG_ROOT_PPN:           root_ppn           <= cfg_data[PPN_W-1:0];
        default:                ;
      endcase
    end
  end

  assign fire     = in_valid && out_ready;
  assign s_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.mode        <= s_tuser;
      in_item.vaddr       <= s_tdata[31:0];
      in_item.access_kind <= s_tdata[33:32];
      in_item.read_data   <= s_tdata[65:34];
    end
  end

  sv32ptw_walk u_walk (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .item               (in_item),
    .translation_enable (translation_enable),
    .root_ppn           (root_ppn),
    .res_valid          (res_valid),
    .res                (res)
  );

  sv32ptw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_valid),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .held      (held)
  );

  assign m_tuser = held.result_kind;
  assign m_tdata = {{(M_TDATA_W-2*PADDR_W-FAULT_W){1'b0}},
                    held.fault_code, held.paddr, held.mem_addr};

endmodule

// File: src/sv32ptw_walk.sv
`timescale 1ns / 1ps

module sv32ptw_walk
  import sv32ptw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  in_item_t         item,
  input  logic             translation_enable,
  input  logic [PPN_W-1:0] root_ppn,
  output logic             res_valid,
  output res_item_t        res
);

  phase_t               phase, phase_next;
  logic [VPN_W-1:0]     pending_vpn0, pending_vpn0_next;
  logic [OFFSET_W-1:0]  pending_offset, pending_offset_next;
  logic [ACCESS_W-1:0]  pending_access, pending_access_next;

  logic [VPN_W-1:0]   vpn1;
  logic [PADDR_W-1:0] l1_addr;
  logic [PADDR_W-1:0] l0_addr;
  logic [PADDR_W-1:0] leaf_paddr;
  logic               perm_ok;

  assign vpn1 = item.vaddr[VADDR_W-1 -: VPN_W];
  // root_ppn << 12 wraps at 32 bits, so only its low 20 bits survive
  assign l1_addr = {root_ppn[PADDR_W-OFFSET_W-1:0], {OFFSET_W{1'b0}}}
                 + {{(PADDR_W-VPN_W-2){1'b0}}, vpn1, 2'b00};
  assign l0_addr = {item.read_data[PTE_W-3:10], {OFFSET_W{1'b0}}}
                 + {{(PADDR_W-VPN_W-2){1'b0}}, pending_vpn0, 2'b00};
  assign leaf_paddr = {item.read_data[PTE_W-3:10], pending_offset};

  always_comb begin
    priority if (pending_access == ACCESS_FETCH) begin
      perm_ok = item.read_data[PTE_X_BIT];
    end else if (pending_access == ACCESS_LOAD) begin
      perm_ok = item.read_data[PTE_R_BIT];
    end else begin
      perm_ok = item.read_data[PTE_W_BIT];  // store, and the unused fourth code
    end
  end

  always_comb begin
    phase_next          = phase;
    pending_vpn0_next   = pending_vpn0;
    pending_offset_next = pending_offset;
    pending_access_next = pending_access;
    res_valid           = 1'b0;
    res                 = '0;
    if (item.mode == MODE_REQUEST) begin
      // a request abandons any walk in progress
      res_valid = 1'b1;
      if (!translation_enable) begin
        phase_next      = PHASE_IDLE;
        res.result_kind = KIND_DONE;
        res.paddr       = item.vaddr;
      end else begin
        phase_next          = PHASE_L1;
        pending_vpn0_next   = item.vaddr[OFFSET_W +: VPN_W];
        pending_offset_next = item.vaddr[OFFSET_W-1:0];
        pending_access_next = item.access_kind;
        res.result_kind     = KIND_READ;
        res.mem_addr        = l1_addr;
      end
    end else begin
      unique case (phase)
        PHASE_L1: begin
          res_valid = 1'b1;
          if (!item.read_data[PTE_V_BIT]) begin
            phase_next      = PHASE_IDLE;
            res.result_kind = KIND_FAULT;
            res.fault_code  = FAULT_L1_INVALID;
          end else if (item.read_data[PTE_R_BIT] || item.read_data[PTE_W_BIT]
                       || item.read_data[PTE_X_BIT]) begin
            phase_next      = PHASE_IDLE;
            res.result_kind = KIND_FAULT;
            res.fault_code  = FAULT_SUPERPAGE;
          end else begin
            phase_next      = PHASE_L0;
            res.result_kind = KIND_READ;
            res.mem_addr    = l0_addr;
          end
        end
        PHASE_L0: begin
          res_valid  = 1'b1;
          phase_next = PHASE_IDLE;
          if (!item.read_data[PTE_V_BIT]) begin
            res.result_kind = KIND_FAULT;
            res.fault_code  = FAULT_L0_INVALID;
          end else if (!perm_ok) begin
            res.result_kind = KIND_FAULT;
            res.fault_code  = FAULT_PERMISSION;
          end else begin
            res.result_kind = KIND_DONE;
            res.paddr       = leaf_paddr;
          end
        end
        default: begin
          // response with no walk pending: dropped
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_IDLE;
      pending_vpn0   <= '0;
      pending_offset <= '0;
      pending_access <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      pending_vpn0   <= pending_vpn0_next;
      pending_offset <= pending_offset_next;
      pending_access <= pending_access_next;
    end
  end

endmodule

// File: src/sv32ptw_out_reg.sv
`timescale 1ns / 1ps

module sv32ptw_out_reg
  import sv32ptw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  logic      res_valid,
  input  res_item_t res,
  output logic      out_ready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output res_item_t held
);

  // free when empty or when the held result leaves this cycle
  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && load && res_valid) begin
      held <= res;
    end
  end

endmodule

// File: src/sv32ptw_check.sv
`timescale 1ns / 1ps

module sv32ptw_check
  import sv32ptw_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]    m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_READ |->
      m_tdata[63:32] == '0 && m_tdata[66:64] == FAULT_NONE && m_tdata[1:0] == 2'b00)
    else $error("read request carries stray fields or unaligned address");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DONE |->
      m_tdata[31:0] == '0 && m_tdata[66:64] == FAULT_NONE)
    else $error("done result carries stray fields");

  a_fault_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == KIND_READ || m_tuser == KIND_DONE ||
      (m_tuser == KIND_FAULT && m_tdata[63:0] == '0 &&
       (m_tdata[66:64] == FAULT_L1_INVALID || m_tdata[66:64] == FAULT_SUPERPAGE ||
        m_tdata[66:64] == FAULT_L0_INVALID || m_tdata[66:64] == FAULT_PERMISSION)))
    else $error("bad result kind or fault code");

endmodule

bind sv32_page_table_walker sv32ptw_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/tb_sv32_page_table_walker.sv
`timescale 1ns / 1ps

module tb_sv32_page_table_walker
  import sv32ptw_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int PHASE_ITEMS    = 145;
  localparam int NUM_PHASES     = 7;

  localparam logic [ACCESS_W-1:0] ACCESS_STORE = 2'd2;
  localparam logic [ACCESS_W-1:0] ACCESS_ODD   = 2'd3;  // handled as a store

  // Expected-result tracker: mirrors the walk state and keeps pending results in order.
  class walk_scoreboard;
    bit                  xlate_on;
    logic [PPN_W-1:0]    root;
    phase_t              phase;
    logic [VPN_W-1:0]    vpn0;
    logic [OFFSET_W-1:0] offset;
    logic [ACCESS_W-1:0] acc;
    res_item_t           expected_q[$];
    int                  errors;

    function new();
      xlate_on = 1'b0;
      root     = '0;
      phase    = PHASE_IDLE;
      vpn0     = '0;
      offset   = '0;
      acc      = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_TRANSLATION_ENABLE)
        xlate_on = val[0];
      else
        root = val[PPN_W-1:0];
    endfunction

    function void push_result(logic [KIND_W-1:0] kind, logic [PADDR_W-1:0] maddr,
                              logic [PADDR_W-1:0] pa, logic [FAULT_W-1:0] code);
      res_item_t r;
      r.result_kind = kind;
      r.mem_addr    = maddr;
      r.paddr       = pa;
      r.fault_code  = code;
      expected_q.push_back(r);
    endfunction

    function void raise_fault(logic [FAULT_W-1:0] code);
      phase = PHASE_IDLE;
      push_result(KIND_FAULT, '0, '0, code);
    endfunction

    function void note_input(in_item_t it);
      logic [PADDR_W-1:0] base;
      logic [PTE_W-1:0]   pte;
      logic               granted;
      pte = it.read_data;
      if (it.mode == MODE_REQUEST) begin
        if (!xlate_on) begin
          phase = PHASE_IDLE;
          push_result(KIND_DONE, '0, it.vaddr, FAULT_NONE);
        end else begin
          vpn0   = it.vaddr[21:12];
          offset = it.vaddr[11:0];
          acc    = it.access_kind;
          phase  = PHASE_L1;
          // root_ppn << 12 wraps at 32 bits
          base = {root[19:0], 12'h000};
          push_result(KIND_READ, base + {20'h0, it.vaddr[31:22], 2'b00}, '0, FAULT_NONE);
        end
      end else if (phase == PHASE_L1) begin
        if (!pte[PTE_V_BIT])
          raise_fault(FAULT_L1_INVALID);
        else if (pte[PTE_R_BIT] || pte[PTE_W_BIT] || pte[PTE_X_BIT])
          raise_fault(FAULT_SUPERPAGE);
        else begin
          phase = PHASE_L0;
          base  = {pte[29:10], 12'h000};
          push_result(KIND_READ, base + {20'h0, vpn0, 2'b00}, '0, FAULT_NONE);
        end
      end else if (phase == PHASE_L0) begin
        case (acc)
          ACCESS_FETCH: granted = pte[PTE_X_BIT];
          ACCESS_LOAD:  granted = pte[PTE_R_BIT];
          default:      granted = pte[PTE_W_BIT];
        endcase
        if (!pte[PTE_V_BIT])
          raise_fault(FAULT_L0_INVALID);
        else if (!granted)
          raise_fault(FAULT_PERMISSION);
        else begin
          phase = PHASE_IDLE;
          push_result(KIND_DONE, '0, {pte[29:10], offset}, FAULT_NONE);
        end
      end
      // response while idle: dropped
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [M_TDATA_W-1:0] data);
      res_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: result_kind %0d mem_addr %h paddr %h fault_code %0d",
               kind, data[31:0], data[63:32], data[66:64]);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.result_kind) begin
        $error("result_kind: expected %0d actual %0d", want.result_kind, kind);
        errors++;
      end
      if (data[31:0] !== want.mem_addr) begin
        $error("mem_addr: expected %h actual %h", want.mem_addr, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.paddr) begin
        $error("paddr: expected %h actual %h", want.paddr, data[63:32]);
        errors++;
      end
      if (data[66:64] !== want.fault_code) begin
        $error("fault_code: expected %0d actual %0d", want.fault_code, data[66:64]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  walk_scoreboard sb = new();

  bit idle_en      = 1'b1;
  bit hold_request = 1'b0;
  bit cur_enable   = 1'b0;
  int sent_count   = 0;
  int quiet_cycles = 0;

  sv32_page_table_walker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sv32_page_table_walker verification failed");
        $finish;
      end
    end
  end

  task automatic send(in_item_t it);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, it.read_data, it.access_kind, it.vaddr};
    s_tuser  <= it.mode;
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
    sent_count++;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // stop offering, wait for every outstanding result, then let ignored items clear
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(bit enable, logic [PPN_W-1:0] root);
    settle();
    cfg_write(CFG_TRANSLATION_ENABLE, CFG_DATA_W'(enable));
    cfg_write(CFG_ROOT_PPN, root);
    cur_enable = enable;
  endtask

  function automatic in_item_t make_request(logic [VADDR_W-1:0] va, logic [ACCESS_W-1:0] acc);
    in_item_t it;
    it.mode        = MODE_REQUEST;
    it.vaddr       = va;
    it.access_kind = acc;
    it.read_data   = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_response(logic [PTE_W-1:0] pte);
    in_item_t it;
    it.mode        = MODE_RESPONSE;
    it.vaddr       = $urandom;
    it.access_kind = ACCESS_W'($urandom_range(0, 3));
    it.read_data   = pte;
    return it;
  endfunction

  function automatic logic [PTE_W-1:0] pointer_pte();
    logic [PTE_W-1:0] pte;
    pte            = $urandom;
    pte[PTE_V_BIT] = 1'b1;
    pte[PTE_R_BIT] = 1'b0;
    pte[PTE_W_BIT] = 1'b0;
    pte[PTE_X_BIT] = 1'b0;
    return pte;
  endfunction

  function automatic logic [PTE_W-1:0] leaf_pte(logic [ACCESS_W-1:0] acc, bit grant);
    logic [PTE_W-1:0] pte;
    pte            = $urandom;
    pte[PTE_V_BIT] = 1'b1;
    case (acc)
      ACCESS_FETCH: pte[PTE_X_BIT] = grant;
      ACCESS_LOAD:  pte[PTE_R_BIT] = grant;
      default:      pte[PTE_W_BIT] = grant;
    endcase
    return pte;
  endfunction

  // one translation with random content; a few walks break off or hit a fault
  task automatic random_walk();
    logic [ACCESS_W-1:0] acc;
    logic [PTE_W-1:0]    pte;
    int                  pick;
    acc = ACCESS_W'($urandom_range(0, 3));
    send(make_request($urandom, acc));
    if (!cur_enable)
      return;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return;
    if (pick == 1) begin
      pte            = $urandom;
      pte[PTE_V_BIT] = 1'b0;
      send(make_response(pte));
      return;
    end
    if (pick == 2) begin
      pte            = $urandom;
      pte[PTE_V_BIT] = 1'b1;
      pte[$urandom_range(PTE_R_BIT, PTE_X_BIT)] = 1'b1;
      send(make_response(pte));
      return;
    end
    send(make_response(pointer_pte()));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return;
    if (pick == 1) begin
      pte            = $urandom;
      pte[PTE_V_BIT] = 1'b0;
      send(make_response(pte));
    end else begin
      send(make_response(leaf_pte(acc, $urandom_range(0, 3) != 0)));
    end
  endtask

  task automatic random_noise();
    in_item_t it;
    it.mode        = 1'($urandom_range(0, 1));
    it.vaddr       = $urandom;
    it.access_kind = ACCESS_W'($urandom_range(0, 3));
    it.read_data   = $urandom;
    send(it);
  endtask

  initial begin
    bit               phase_enable [NUM_PHASES];
    logic [PPN_W-1:0] phase_root   [NUM_PHASES];
    int               target;
    bit               mid_pause_done;

    phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    phase_root   = '{'0, PPN_W'($urandom), PPN_W'($urandom), PPN_W'($urandom),
                     '1, PPN_W'($urandom), PPN_W'($urandom)};
    mid_pause_done = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through with translation off, and a stray response
    apply_settings(1'b0, '0);
    send(make_request(32'h0000_0000, ACCESS_FETCH));
    send(make_request(32'hffff_ffff, ACCESS_ODD));
    send(make_response(32'hffff_ffff));

    // largest root: both PTE addresses wrap
    apply_settings(1'b1, '1);
    send(make_request(32'hffff_ffff, ACCESS_FETCH));
    send(make_response(32'hffff_fc01));
    send(make_response(32'hffff_ffff));
    send(make_request(32'h0000_0000, ACCESS_LOAD));
    send(make_response(32'h0000_0000));
    send(make_request(32'h1234_5678, ACCESS_LOAD));
    send(make_response(32'h0000_0003));
    send(make_request(32'h8000_0fff, ACCESS_STORE));
    send(make_response(32'h0000_0001));
    send(make_response(32'hffff_fffe));
    send(make_request(32'h7fff_f000, ACCESS_FETCH));
    send(make_response(32'h0000_0401));
    send(make_response(32'h0000_0007));
    send(make_request(32'hdead_beef, ACCESS_ODD));
    send(make_response(32'hffff_fc01));
    send(make_response(32'h0000_0005));
    // new request abandons the walk in progress
    send(make_request(32'h0040_1abc, ACCESS_LOAD));
    send(make_request(32'hffc0_2def, ACCESS_FETCH));
    send(make_response(32'h0000_0801));
    send(make_response(32'h0000_0c09));

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_settings(phase_enable[p], phase_root[p]);
      idle_en = (p != NUM_PHASES - 1);
      if (p == 2)
        hold_request = 1'b1;
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) begin
        if (p == 4 && !mid_pause_done && sent_count >= target - PHASE_ITEMS / 2) begin
          mid_pause_done = 1'b1;
          settle();
        end
        if ($urandom_range(0, 9) == 0)
          random_noise();
        else
          random_walk();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("sv32_page_table_walker verification clean");
    else
      $display("sv32_page_table_walker verification failed");
    $finish;
  end

endmodule

// File: filelist.f
src/sv32ptw_pkg.sv
src/sv32ptw_walk.sv
src/sv32ptw_out_reg.sv
src/sv32_page_table_walker.sv
src/sv32ptw_check.sv
tb/tb_sv32_page_table_walker.sv
